@@ hdl/sgdm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgdm_pkg
// Shared widths, defaults, register codes and the configuration record of the
// SGD momentum update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgdm_pkg;

    localparam int IDX_W     = 12;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int DEF_DATA_WIDTH   = 32;
    localparam int DEF_FRAC_BITS    = 24;

    localparam logic [CFG_W-1:0] LR_RESET = 25'd167772;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_MOMENTUM      = 3'd1,
        REG_DAMPENING     = 3'd2,
        REG_DECAY         = 3'd3,
        REG_NESTEROV      = 3'd4
    } cfg_reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] lr;
        logic [CFG_W-1:0] mom;
        logic [CFG_W-1:0] damp;
        logic [CFG_W-1:0] decay;
        logic             nest;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/sgd_momentum_update.sv @@
// ----------------------------------------------------------------------------
// sgd_momentum_update
// Per-element SGD step with weight decay, momentum, dampening and Nesterov
// lookahead in signed fixed point (FRAC_BITS fraction bits, saturating).
// The block is an eight-stage pipeline that, unless stalled, takes one input
// beat per clock and returns one result beat per input, in order. Stages:
// decay product, decay sum, dampened-gradient product, buffer update, Nesterov
// product, effective gradient, learning-rate product, final subtraction. The
// momentum buffer is a single one-read one-write RAM with registered read
// data, read in stage three and written in stage four; a beat for the same
// element right behind another gets the new buffer value forwarded, so the
// rate stays at one beat per cycle for any index pattern unless stalled. An
// output register with a skid stage lets new beats in while a result waits.
// Buffer entries hold no reset value: an element must see a first-step beat
// before its buffer is read. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgd_momentum_update #(
    parameter int BUFFER_DEPTH = sgdm_pkg::DEF_BUFFER_DEPTH,
    parameter int DATA_WIDTH   = sgdm_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS    = sgdm_pkg::DEF_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgdm_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sgdm_pkg::IDX_W-1:0]         s_elem_index,
    input  logic signed [DATA_WIDTH-1:0]       s_param_value,
    input  logic signed [DATA_WIDTH-1:0]       s_grad_value,
    input  logic                               s_first_step,
    input  logic                               s_has_grad,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sgdm_pkg::IDX_W-1:0]         m_out_index,
    output logic signed [DATA_WIDTH-1:0]       m_new_param
);

    import sgdm_pkg::*;

    localparam int ADDR_W   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam bit IS_POW2  = ((BUFFER_DEPTH & (BUFFER_DEPTH - 1)) == 0);
    localparam int FW       = ((CFG_W > FRAC_BITS + 1) ? CFG_W : FRAC_BITS + 1) + 1;
    localparam int PW       = DATA_WIDTH + FW;
    localparam int SW       = PW + 1;
    localparam int DW       = DATA_WIDTH;

    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [FW-1:0] ONE_Q =
        {{(FW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // ------------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
        if (x > SAT_HI) begin
            return SAT_HI[DW-1:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[DW-1:0];
        end
        return x[DW-1:0];
    endfunction

    // exact product, low fraction bits dropped (rounds toward minus infinity)
    function automatic logic signed [PW-1:0] mulq(input logic signed [FW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [PW-1:0] prod;
        prod = PW'(a) * PW'(b);
        return prod >>> FRAC_BITS;
    endfunction

    function automatic logic signed [FW-1:0] fac(input logic [CFG_W-1:0] f);
        return FW'(f);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = idx;
        if (BUFFER_DEPTH == 1) begin
            return '0;
        end
        if (IS_POW2) begin
            return ADDR_W'(r);
        end
        // constant-divisor remainder, one compare and subtract per bit
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (longint'(r) >= (longint'(BUFFER_DEPTH) << k)) begin
                r = r - IDX_W'(longint'(BUFFER_DEPTH) << k);
            end
        end
        return ADDR_W'(r);
    endfunction

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_LEARNING_RATE: cfg_next.lr    = cfg_wdata;
                REG_MOMENTUM:      cfg_next.mom   = cfg_wdata;
                REG_DAMPENING:     cfg_next.damp  = cfg_wdata;
                REG_DECAY:         cfg_next.decay = cfg_wdata;
                REG_NESTEROV:      cfg_next.nest  = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lr    <= LR_RESET;
            cfg_reg.mom   <= '0;
            cfg_reg.damp  <= '0;
            cfg_reg.decay <= '0;
            cfg_reg.nest  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic                 mom_nz;
    logic signed [FW-1:0] keep_q;

    assign mom_nz = (cfg_reg.mom != '0);
    assign keep_q = ONE_Q - fac(cfg_reg.damp);

    // ------------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------------
    logic       pipe_en;
    logic       accept;
    logic [8:1] vld_reg;
    logic       skid_valid_reg;
    logic       m_valid_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[7:1], accept};
        end
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [IDX_W-1:0]     idx5_reg, idx6_reg, idx7_reg, idx8_reg;
    logic signed [DW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg;
    logic                 has1_reg, has2_reg, has3_reg, has4_reg;
    logic                 has5_reg, has6_reg, has7_reg, has8_reg;
    logic                 first1_reg, first2_reg, first3_reg, first4_reg;
    logic signed [DW-1:0] g1_reg, g2_reg;
    logic [ADDR_W-1:0]    addr2_reg, addr3_reg, addr4_reg, addr5_reg;
    logic signed [PW-1:0] pd2_reg, pk4_reg, pn6_reg, pl8_reg;
    logic signed [DW-1:0] gd3_reg, gd4_reg, gd5_reg, gd6_reg;
    logic signed [DW-1:0] buf5_reg, buf6_reg, ge7_reg;
    logic                 w5_reg;

    logic signed [DW-1:0] gd3_next;
    logic signed [DW-1:0] buf5_next;
    logic signed [DW-1:0] ge7_next;
    logic signed [DW-1:0] res_next;
    logic                 w5_next;
    logic                 fwd_sel;
    logic signed [DW-1:0] buf_src;
    logic signed [PW-1:0] pm4;
    logic [DW-1:0]        ram_rdata;
    logic                 ram_we;

    assign gd3_next = sat_dw(SW'(g2_reg) + SW'(pd2_reg));

    // beat right ahead wrote the same entry on the edge this one read it
    assign fwd_sel   = w5_reg && (addr5_reg == addr4_reg);
    assign buf_src   = fwd_sel ? buf5_reg : $signed(ram_rdata);
    assign pm4       = mulq(fac(cfg_reg.mom), buf_src);
    assign buf5_next = first4_reg ? gd4_reg : sat_dw(SW'(pm4) + SW'(pk4_reg));
    assign w5_next   = vld_reg[4] && has4_reg && mom_nz;
    assign ram_we    = pipe_en && w5_next;

    always_comb begin
        if (!mom_nz) begin
            ge7_next = gd6_reg;
        end else if (cfg_reg.nest) begin
            ge7_next = sat_dw(SW'(gd6_reg) + SW'(pn6_reg));
        end else begin
            ge7_next = buf6_reg;
        end
    end

    assign res_next = has8_reg ? sat_dw(SW'(p8_reg) - SW'(pl8_reg)) : p8_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 1: input beat
            idx1_reg   <= s_elem_index;
            p1_reg     <= s_param_value;
            g1_reg     <= s_grad_value;
            first1_reg <= s_first_step;
            has1_reg   <= s_has_grad;
            // stage 2: decay product, buffer slot
            idx2_reg   <= idx1_reg;
            addr2_reg  <= slot_of(idx1_reg);
            p2_reg     <= p1_reg;
            g2_reg     <= g1_reg;
            first2_reg <= first1_reg;
            has2_reg   <= has1_reg;
            pd2_reg    <= mulq(fac(cfg_reg.decay), p1_reg);
            // stage 3: decayed gradient
            idx3_reg   <= idx2_reg;
            addr3_reg  <= addr2_reg;
            p3_reg     <= p2_reg;
            first3_reg <= first2_reg;
            has3_reg   <= has2_reg;
            gd3_reg    <= gd3_next;
            // stage 4: dampened gradient product, buffer read data arrives
            idx4_reg   <= idx3_reg;
            addr4_reg  <= addr3_reg;
            p4_reg     <= p3_reg;
            first4_reg <= first3_reg;
            has4_reg   <= has3_reg;
            gd4_reg    <= gd3_reg;
            pk4_reg    <= mulq(keep_q, gd3_reg);
            // stage 5: new buffer value
            idx5_reg   <= idx4_reg;
            addr5_reg  <= addr4_reg;
            p5_reg     <= p4_reg;
            has5_reg   <= has4_reg;
            gd5_reg    <= gd4_reg;
            buf5_reg   <= buf5_next;
            w5_reg     <= w5_next;
            // stage 6: lookahead product
            idx6_reg   <= idx5_reg;
            p6_reg     <= p5_reg;
            has6_reg   <= has5_reg;
            gd6_reg    <= gd5_reg;
            buf6_reg   <= buf5_reg;
            pn6_reg    <= mulq(fac(cfg_reg.mom), buf5_reg);
            // stage 7: effective gradient
            idx7_reg   <= idx6_reg;
            p7_reg     <= p6_reg;
            has7_reg   <= has6_reg;
            ge7_reg    <= ge7_next;
            // stage 8: step product
            idx8_reg   <= idx7_reg;
            p8_reg     <= p7_reg;
            has8_reg   <= has7_reg;
            pl8_reg    <= mulq(fac(cfg_reg.lr), ge7_reg);
        end
    end

    sgdm_mom_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DW)
    ) u_mom_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr4_reg),
        .wr_data (buf5_next),
        .rd_en   (pipe_en),
        .rd_addr (addr3_reg),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // output register and skid stage
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]     m_idx_reg, skid_idx_reg;
    logic signed [DW-1:0] m_param_reg, skid_param_reg;
    logic                 out_hold;
    logic                 pipe_out;

    assign out_hold = m_valid_reg && !m_ready;
    assign pipe_out = pipe_en && vld_reg[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_hold) begin
            if (pipe_out) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= pipe_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_hold) begin
            if (pipe_out) begin
                skid_idx_reg   <= idx8_reg;
                skid_param_reg <= res_next;
            end
        end else if (skid_valid_reg) begin
            m_idx_reg   <= skid_idx_reg;
            m_param_reg <= skid_param_reg;
        end else begin
            m_idx_reg   <= idx8_reg;
            m_param_reg <= res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_idx_reg;
    assign m_new_param = m_param_reg;

`ifndef SYNTH
    ap_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid beat held without an output beat");

    ap_skid_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(vld_reg))
        else $error("pipeline advanced while the skid stage was full");

    ap_write_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (mom_nz && pipe_en && vld_reg[4] && has4_reg))
        else $error("buffer write without a live momentum beat");

    ap_forward_live: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_sel |-> (vld_reg[5] && mom_nz))
        else $error("forward taken from an empty stage");
`endif

endmodule

`default_nettype wire

@@ hdl/sgdm_mom_ram.sv @@
// ----------------------------------------------------------------------------
// sgdm_mom_ram
// Momentum buffer storage: one write port, one read port, registered read
// data with a read enable so the data holds while the pipeline stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgdm_mom_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write: a same-edge write is not seen here
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
